FILE: hw/rtl/dataset_sort_and_statistics_macros.svh
// Assertion macros used by the top level of the sort and statistics block.
`ifndef DATASET_SORT_AND_STATISTICS_MACROS_SVH
`define DATASET_SORT_AND_STATISTICS_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define DSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define DSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/dss_pkg.sv
// Shared types and constants of the sort and statistics block.
`default_nettype none
package dss_pkg;

    localparam int VALUE_W = 8;

    // Status that the sort engine reports to the top level.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] largest;
        logic [VALUE_W-1:0] smallest;
        logic [VALUE_W-1:0] median;
    } dss_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dss_divider.sv
// Restoring divider that yields the truncated mean, one quotient bit per cycle.
`default_nettype none
module dss_divider import dss_pkg::*; #(
    parameter int SUM_W = 15,
    parameter int CNT_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [SUM_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    // Shift one dividend bit into the remainder and try the subtraction.
    always_comb begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, div_reg}) : CNT_W'(trial);
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/dss_sorter.sv
// Sample and scratch memories with the bottom-up merge sort sequencer.
`default_nettype none
module dss_sorter import dss_pkg::*; #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load_we,
    input  wire logic [$clog2(MAX_SAMPLES)-1:0]   load_addr,
    input  wire logic [VALUE_W-1:0] load_data,
    input  wire logic               start,
    input  wire logic [$clog2(MAX_SAMPLES+1)-1:0] count,
    input  wire logic [$clog2(MAX_SAMPLES)-1:0]   rd_addr,
    output logic [VALUE_W-1:0]      rd_data,
    output dss_stat_t               stat
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int RW = CW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_CR    = 4'd4;
    localparam logic [3:0] S_CW    = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_ST1   = 4'd7;
    localparam logic [3:0] S_ST2   = 4'd8;
    localparam logic [3:0] S_ST3   = 4'd9;

    logic [VALUE_W-1:0] store_mem   [MAX_SAMPLES];
    logic [VALUE_W-1:0] scratch_mem [MAX_SAMPLES];

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [RW-1:0]      width_reg, width_next;
    logic [RW-1:0]      lo_reg, lo_next;
    logic [RW-1:0]      mid_reg, mid_next;
    logic [RW-1:0]      hi_reg, hi_next;
    logic [RW-1:0]      a_reg, a_next;
    logic [RW-1:0]      b_reg, b_next;
    logic [RW-1:0]      w_reg, w_next;
    logic [VALUE_W-1:0] rda_reg, rdb_reg, scr_rd_reg;
    logic [VALUE_W-1:0] largest_reg, largest_next;
    logic [VALUE_W-1:0] smallest_reg, smallest_next;
    logic [VALUE_W-1:0] median_reg, median_next;
    logic               done_reg, done_next;

    logic               st_we, scr_we;
    logic [AW-1:0]      st_waddr, ra, rb;
    logic [VALUE_W-1:0] st_wdata, scr_wdata;
    logic [RW-1:0]      n_ext, mid_calc, end_calc, lo_step, width_dbl;
    logic               a_live, b_live, take_a;
    logic [AW-1:0]      half;
    logic [VALUE_W:0]   pair_sum;

    always_comb begin
        n_ext     = RW'(n_reg);
        mid_calc  = lo_reg + width_reg;
        end_calc  = mid_calc + width_reg;
        lo_step   = lo_reg + (width_reg << 1);
        width_dbl = width_reg << 1;
        a_live    = (a_reg < mid_reg);
        b_live    = (b_reg < hi_reg);
        take_a    = a_live && (!b_live || (rda_reg <= rdb_reg));
        half      = AW'(n_reg >> 1);
        pair_sum  = {1'b0, rda_reg} + {1'b0, rdb_reg};
    end

    // Sequence the merge passes, the copy back and the statistics reads.
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        w_next        = w_reg;
        largest_next  = largest_reg;
        smallest_next = smallest_reg;
        median_next   = median_reg;
        done_next     = 1'b0;
        st_we         = load_we;
        st_waddr      = load_addr;
        st_wdata      = load_data;
        scr_we        = 1'b0;
        scr_wdata     = take_a ? rda_reg : rdb_reg;
        ra            = rd_addr;
        rb            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    n_next     = count;
                    width_next = RW'(1);
                    lo_next    = '0;
                    state_next = (count > CW'(1)) ? S_SETUP : S_ST1;
                end
            end
            S_SETUP: begin
                mid_next   = mid_calc;
                hi_next    = (end_calc > n_ext) ? n_ext : end_calc;
                a_next     = lo_reg;
                b_next     = mid_calc;
                w_next     = lo_reg;
                state_next = S_RD;
            end
            S_RD: begin
                ra         = a_reg[AW-1:0];
                rb         = b_reg[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP: begin
                // Write the smaller head to scratch; ties take the left run.
                scr_we = 1'b1;
                if (take_a) begin
                    a_next = a_reg + 1'b1;
                end else begin
                    b_next = b_reg + 1'b1;
                end
                if (w_reg + 1'b1 == hi_reg) begin
                    w_next     = lo_reg;
                    state_next = S_CR;
                end else begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_CR: begin
                state_next = S_CW;
            end
            S_CW: begin
                st_we    = 1'b1;
                st_waddr = w_reg[AW-1:0];
                st_wdata = scr_rd_reg;
                w_next   = w_reg + 1'b1;
                state_next = (w_reg + 1'b1 == hi_reg) ? S_NEXT : S_CR;
            end
            S_NEXT: begin
                // Advance to the next pair of runs, or to the next run width.
                if (lo_step + width_reg < n_ext) begin
                    lo_next    = lo_step;
                    state_next = S_SETUP;
                end else if (width_dbl < n_ext) begin
                    width_next = width_dbl;
                    lo_next    = '0;
                    state_next = S_SETUP;
                end else begin
                    state_next = S_ST1;
                end
            end
            S_ST1: begin
                ra         = AW'(n_reg - 1'b1);
                rb         = '0;
                state_next = S_ST2;
            end
            S_ST2: begin
                largest_next  = rda_reg;
                smallest_next = rdb_reg;
                ra            = half;
                rb            = half - 1'b1;
                state_next    = S_ST3;
            end
            S_ST3: begin
                median_next = n_reg[0] ? rda_reg : pair_sum[VALUE_W:1];
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold both memories; reads are registered.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        rda_reg <= store_mem[ra];
        rdb_reg <= store_mem[rb];
        if (scr_we) begin
            scratch_mem[w_reg[AW-1:0]] <= scr_wdata;
        end
        scr_rd_reg <= scratch_mem[w_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        n_reg        <= n_next;
        width_reg    <= width_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        largest_reg  <= largest_next;
        smallest_reg <= smallest_next;
        median_reg   <= median_next;
    end

    assign rd_data       = rda_reg;
    assign stat.done     = done_reg;
    assign stat.largest  = largest_reg;
    assign stat.smallest = smallest_reg;
    assign stat.median   = median_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/dataset_sort_and_statistics.sv
// Top level of the sort and statistics block: stream ports, counters, result output.
`default_nettype none
`include "dataset_sort_and_statistics_macros.svh"
// Samples arrive one per cycle on the input stream while s_tready is high and are
// written to the sample memory; tlast closes the set. Up to MAX_SAMPLES samples are
// kept and later ones are dropped and flagged. After the last sample the merge
// sequencer sorts the set in the sample memory through a scratch memory: each merge
// pass reads and compares the run heads and writes the smaller to scratch, then reads
// each element back from scratch and copies it to the sample memory, with a setup
// step per merged pair; the statistics reads follow the last pass. The mean comes
// from a serial divider that runs alongside the sort. Results then leave in descending
// order through the registered memory read, the next only after the last is taken;
// the input stream is held off from the last sample until the last result is taken.
module dataset_sort_and_statistics import dss_pkg::*; #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] sample
    input  wire logic        s_tlast,   // final_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] sorted_value, [13:8] position, [21:14] largest, [29:22] smallest,
    // [37:30] average, [45:38] middle_value, [52:46] sample_count, [55:53] zero
    output logic [55:0]      m_tdata,
    output logic [0:0]       m_tuser,   // [0] dropped_flag
    output logic             m_tlast    // run_end
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = VALUE_W + CW;

    localparam logic [2:0] T_LOAD      = 3'd0;
    localparam logic [2:0] T_SORT      = 3'd1;
    localparam logic [2:0] T_EMIT_RD   = 3'd2;
    localparam logic [2:0] T_EMIT_WAIT = 3'd3;
    localparam logic [2:0] T_EMIT_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               sorted_reg, sorted_next;
    logic               meaned_reg, meaned_next;
    logic [VALUE_W-1:0] mean_reg, mean_next;
    logic               valid_reg, valid_next;
    logic [55:0]        data_reg, data_next;
    logic               last_reg, last_next;

    logic               in_acc, out_acc, has_room, start;
    logic               load_we;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;
    dss_stat_t          stat;
    logic               div_done;
    logic [SW-1:0]      quotient;
    logic               is_final;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign has_room = (kept_reg < CW'(MAX_SAMPLES));
    assign load_we  = in_acc && has_room;
    assign start    = in_acc && s_tlast;
    assign rd_addr  = AW'(kept_reg - 1'b1) - idx_reg;
    assign is_final = (CW'(idx_reg) == kept_reg - 1'b1);

    dss_sorter #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_sorter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_we   (load_we),
        .load_addr (kept_reg[AW-1:0]),
        .load_data (s_tdata),
        .start     (start),
        .count     (kept_next),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    dss_divider #(
        .SUM_W(SW),
        .CNT_W(CW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (sum_next),
        .divisor  (kept_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // Collect samples, wait for sort and mean, then stream results.
    always_comb begin
        state_next  = state_reg;
        kept_next   = kept_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        sorted_next = sorted_reg;
        meaned_next = meaned_reg;
        mean_next   = mean_reg;
        valid_next  = valid_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        if (in_acc) begin
            if (has_room) begin
                kept_next = kept_reg + 1'b1;
                sum_next  = sum_reg + SW'(s_tdata);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (div_done) begin
            meaned_next = 1'b1;
            mean_next   = quotient[VALUE_W-1:0];
        end
        if (stat.done) begin
            sorted_next = 1'b1;
        end
        unique case (state_reg)
            T_LOAD: begin
                if (start) begin
                    sorted_next = 1'b0;
                    meaned_next = 1'b0;
                    idx_next    = '0;
                    state_next  = T_SORT;
                end
            end
            T_SORT: begin
                if (sorted_reg && meaned_reg) begin
                    state_next = T_EMIT_RD;
                end
            end
            T_EMIT_RD: begin
                state_next = T_EMIT_WAIT;
            end
            T_EMIT_WAIT: begin
                data_next  = {3'b000, 7'(kept_reg), stat.median, mean_reg,
                              stat.smallest, stat.largest, 6'(idx_reg), rd_data};
                last_next  = is_final;
                valid_next = 1'b1;
                state_next = T_EMIT_OUT;
            end
            T_EMIT_OUT: begin
                if (out_acc) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        kept_next  = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = T_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = T_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_LOAD;
            kept_reg   <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            sorted_reg <= 1'b0;
            meaned_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            kept_reg   <= kept_next;
            sum_reg    <= sum_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
            sorted_reg <= sorted_next;
            meaned_reg <= meaned_next;
            idx_reg    <= idx_next;
        end
        mean_reg <= mean_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign s_tready   = (state_reg == T_LOAD);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = ovf_reg;
    assign m_tlast    = last_reg;

    `DSS_ASSERT_SAME(a_count_bound, 1'b1, kept_reg <= CW'(MAX_SAMPLES))
    `DSS_ASSERT_SAME(a_valid_emit, m_tvalid, state_reg == T_EMIT_OUT)
    `DSS_ASSERT_NEXT(a_run_clear, out_acc && m_tlast, kept_reg == '0 && !ovf_reg && s_tready)
    `DSS_ASSERT_SAME(a_nonempty_run, state_reg == T_SORT, kept_reg != '0)

endmodule
`default_nettype wire
